@@ rtl/resume_sequencer_with_timeouts_top_macros.svh @@
// ---------------------------------------------------------------------------
// Resume sequencer assertion macros
// Shared assertion wrappers for the checker of the resume sequencer.
// ---------------------------------------------------------------------------
`ifndef RESUME_SEQUENCER_WITH_TIMEOUTS_TOP_MACROS_SVH
`define RESUME_SEQUENCER_WITH_TIMEOUTS_TOP_MACROS_SVH

// Assertion that is switched off while reset is high
`define RSQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that also holds across reset
`define RSQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/rsq_pkg.sv @@
// ---------------------------------------------------------------------------
// Resume sequencer package
// Types, codes and widths shared by the resume sequencer modules.
// ---------------------------------------------------------------------------
package rsq_pkg;

   localparam int unsigned TS_W       = 32;
   localparam int unsigned COUNT_W    = 8;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned REQ_USER_W = 3;
   localparam int unsigned RSP_DATA_W = 8;

   // Register reset values
   localparam logic [COUNT_W-1:0] STABLE_NEEDED_RST  = 8'd3;
   localparam logic [TS_W-1:0]    CHECK_TIMEOUT_RST  = 32'd1000;
   localparam logic [TS_W-1:0]    OUTPUT_TIMEOUT_RST = 32'd1000;
   localparam logic [COUNT_W-1:0] COUNT_MAX          = 8'hFF;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STABLE_NEEDED  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHECK_TIMEOUT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_TIMEOUT = 2'd2;

   typedef enum logic [2:0] {
      MODE_IDLE     = 3'd0,
      MODE_OVERRIDE = 3'd1,
      MODE_CHECK    = 3'd2,
      MODE_READY    = 3'd3,
      MODE_RESUMED  = 3'd4,
      MODE_TIMEOUT  = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      ACT_OVERRIDE_END  = 3'd0,
      ACT_STABLE_REPORT = 3'd1,
      ACT_FIRST_OUTPUT  = 3'd2,
      ACT_FORCE_TIMEOUT = 3'd3,
      ACT_SET_OVERRIDE  = 3'd4,
      ACT_CHECK_TIMEOUT = 3'd5
   } action_type;

   typedef struct packed {
      logic [COUNT_W-1:0] stable_needed;
      logic [TS_W-1:0]    check_limit;
      logic [TS_W-1:0]    output_timeout;
   } cfg_type;

   typedef struct packed {
      action_type      action;
      logic [TS_W-1:0] timestamp;
      logic            override_on;
   } req_item_type;

   typedef struct packed {
      logic     timeout_fired;
      mode_type mode;
   } rsp_item_type;

endpackage

@@ rtl/rsq_csr.sv @@
// ---------------------------------------------------------------------------
// Resume sequencer configuration registers
// Holds the stable report count and the two timeout limits.
// ---------------------------------------------------------------------------
module rsq_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rsq_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rsq_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output rsq_pkg::cfg_type                 cfg
);
   import rsq_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Always take a write
   assign csr_ready = 1'b1;

   // Decode the write into the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_STABLE_NEEDED:  cfg_in.stable_needed  = csr_wdata[COUNT_W-1:0];
            CSR_CHECK_TIMEOUT:  cfg_in.check_limit    = csr_wdata[TS_W-1:0];
            CSR_OUTPUT_TIMEOUT: cfg_in.output_timeout = csr_wdata[TS_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stable_needed  <= STABLE_NEEDED_RST;
         cfg_ff.check_limit    <= CHECK_TIMEOUT_RST;
         cfg_ff.output_timeout <= OUTPUT_TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/rsq_in_stage.sv @@
// ---------------------------------------------------------------------------
// Resume sequencer input register
// Captures one event per transfer and hands it to the sequencer engine.
// ---------------------------------------------------------------------------
module rsq_in_stage (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rsq_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [rsq_pkg::REQ_USER_W-1:0]    req_tuser,
   input  logic                              take,
   output logic                              item_valid,
   output rsq_pkg::req_item_type             item
);
   import rsq_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         load;

   // Accept when empty or when the held event moves on this cycle
   assign req_tready = !valid_ff || take;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.action      <= action_type'(req_tuser);
         item_ff.timestamp   <= req_tdata[TS_W-1:0];
         item_ff.override_on <= req_tdata[TS_W];
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ rtl/rsq_engine.sv @@
// ---------------------------------------------------------------------------
// Resume sequencer engine
// Applies one event to the mode, start time and stable count, and registers
// the result.
// ---------------------------------------------------------------------------
module rsq_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  rsq_pkg::cfg_type       cfg,
   input  logic                   item_valid,
   input  rsq_pkg::req_item_type  item,
   output logic                   take,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsq_pkg::rsp_item_type  rsp_item
);
   import rsq_pkg::*;

   mode_type           mode_ff;
   mode_type           mode_in;
   logic [TS_W-1:0]    start_ff;
   logic [TS_W-1:0]    start_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [COUNT_W-1:0] count_inc;
   logic [TS_W-1:0]    elapsed;
   logic               check_over;
   logic               ready_over;
   logic               fire;
   logic               step;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_item_type       rsp_ff;

   // Move an event on when the result register is free or being drained
   assign take = !rsp_valid_ff || rsp_ready;
   assign step = item_valid && take;

   // Wrap-around elapsed time and limit checks
   assign elapsed    = item.timestamp - start_ff;
   assign check_over = elapsed > cfg.check_limit;
   assign ready_over = elapsed > cfg.output_timeout;
   assign count_inc  = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;

   // Next mode
   always_comb begin
      mode_in = mode_ff;
      if (step) begin
         case (item.action)
            ACT_OVERRIDE_END: begin
               if (mode_ff == MODE_OVERRIDE || mode_ff == MODE_IDLE) begin
                  mode_in = MODE_CHECK;
               end
            end
            ACT_STABLE_REPORT: begin
               if (mode_ff == MODE_CHECK && count_inc >= cfg.stable_needed) begin
                  mode_in = MODE_READY;
               end
            end
            ACT_FIRST_OUTPUT: begin
               if (mode_ff == MODE_READY) begin
                  mode_in = MODE_RESUMED;
               end
            end
            ACT_FORCE_TIMEOUT: mode_in = MODE_TIMEOUT;
            ACT_SET_OVERRIDE: begin
               if (item.override_on) begin
                  mode_in = MODE_OVERRIDE;
               end
            end
            ACT_CHECK_TIMEOUT: begin
               if (fire) begin
                  mode_in = MODE_TIMEOUT;
               end
            end
            default: mode_in = mode_ff;
         endcase
      end
   end

   // Timeout flag, start time and stable count
   always_comb begin
      fire     = 1'b0;
      start_in = start_ff;
      count_in = count_ff;
      if (item.action == ACT_CHECK_TIMEOUT) begin
         fire = (mode_ff == MODE_CHECK && check_over)
             || (mode_ff == MODE_READY && ready_over);
      end
      if (step) begin
         if (item.action == ACT_OVERRIDE_END
             && (mode_ff == MODE_OVERRIDE || mode_ff == MODE_IDLE)) begin
            start_in = item.timestamp;
            count_in = '0;
         end else if (item.action == ACT_STABLE_REPORT && mode_ff == MODE_CHECK) begin
            count_in = count_inc;
         end
      end
   end

   // Result valid: set on a new event, drop once transferred
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         start_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         start_ff     <= start_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the result until transferred
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff.mode          <= mode_in;
         rsp_ff.timeout_fired <= fire;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

@@ rtl/resume_sequencer_with_timeouts_top.sv @@
// ---------------------------------------------------------------------------
// Resume sequencer with timeouts
// Steps the resume after a safety override through check, ready and resumed,
// with timeouts measured from the start of the check.
// ---------------------------------------------------------------------------
// Usage:
//   req_ carries one event per transfer: action in req_tuser, timestamp and
//   override flag in req_tdata. rsp_ returns one result per event: the mode
//   after the event and a flag set when a check event caused the timeout.
//   csr_ writes the stable report count (index 0), the check limit (1) and
//   the ready limit (2); write only while no event is in flight.
//   An event passes through the input register and then the result
//   register; it moves on once the result register is free or being drained.
//   Rate: one event per cycle while the receiver takes each result, with
//   the subtract-and-compare path lying between those two registers.
//   Reset clears the mode to idle, start time and stable count to zero,
//   and loads the register defaults (3, 1000, 1000).
//   When the receiver stalls, the result holds and one more event waits in
//   the input register; req_tready then drops until the result moves.
// ---------------------------------------------------------------------------
module resume_sequencer_with_timeouts_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [31:0] timestamp, [32] override_on, [39:33] zero
   input  logic [rsq_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [2:0] action
   input  logic [rsq_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [2:0] mode, [3] timeout_fired, [7:4] zero
   output logic [rsq_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rsq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rsq_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import rsq_pkg::*;

   cfg_type      cfg;
   logic         take;
   logic         item_valid;
   req_item_type item;
   rsp_item_type rsp_item;

   // Configuration registers
   rsq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Input register
   rsq_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   // Sequencer and result register
   rsq_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_item   (rsp_item)
   );

   // Pack the result, zero filled to a whole byte
   assign rsp_tdata = {{(RSP_DATA_W - 4){1'b0}}, rsp_item.timeout_fired, rsp_item.mode};

endmodule

@@ rtl/rsq_checker.sv @@
// ---------------------------------------------------------------------------
// Resume sequencer port checker
// Watches the top level ports and flags behaviour the design must not show.
// ---------------------------------------------------------------------------
`include "resume_sequencer_with_timeouts_top_macros.svh"

module rsq_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [rsq_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import rsq_pkg::*;

   // A fired timeout always lands in the timed-out mode
   `RSQ_ASSERT(a_fire_mode, clock, reset, rsp_tvalid && rsp_tdata[3] |-> rsp_tdata[2:0] == MODE_TIMEOUT, "timeout fired outside timed-out mode")

   // Input is only refused while the result side is stalled
   `RSQ_ASSERT(a_refuse_stall, clock, reset, req_tvalid && !req_tready |-> rsp_tvalid && !rsp_tready, "input refused without output stall")

   // No result straight after reset
   `RSQ_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "result valid after reset")

   // A stalled result holds
   `RSQ_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

endmodule

bind resume_sequencer_with_timeouts_top rsq_checker u_rsq_checker (.*);

@@ dv/resume_sequencer_with_timeouts_top_test.sv @@
// ---------------------------------------------------------------------------
// Resume sequencer testbench
// Drives events into the resume sequencer and predicts each mode and timeout
// flag in a scoreboard. It opens with a short directed part that covers every
// action, the unused action codes, wrong-mode events and timestamp wrap. It
// then runs random resume sequences under several register settings, with
// random idle bursts on both sides of the stream.
// ---------------------------------------------------------------------------
module resume_sequencer_with_timeouts_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rsq_pkg::*;

   // Action codes that the block has no meaning for
   localparam logic [2:0] ACT_RESERVED_6 = 3'd6;
   localparam logic [2:0] ACT_RESERVED_7 = 3'd7;

   localparam int unsigned CYCLE_LIMIT = 500000;

   // -------------------------------------------------------------------------
   // Scoreboard: own copy of the sequencer state and its registers
   // -------------------------------------------------------------------------
   class resume_scoreboard;
      cfg_type      regs;
      mode_type     mode;
      logic [31:0]  start_ts;
      logic [7:0]   stable_cnt;
      rsp_item_type awaited_results[$];
      int unsigned  fail_count;

      function new();
         regs.stable_needed  = STABLE_NEEDED_RST;
         regs.check_limit    = CHECK_TIMEOUT_RST;
         regs.output_timeout = OUTPUT_TIMEOUT_RST;
         mode       = MODE_IDLE;
         start_ts   = '0;
         stable_cnt = '0;
         fail_count = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_STABLE_NEEDED:  regs.stable_needed  = value[COUNT_W-1:0];
            CSR_CHECK_TIMEOUT:  regs.check_limit    = value;
            CSR_OUTPUT_TIMEOUT: regs.output_timeout = value;
            default: ;
         endcase
      endfunction

      // Advance the sequencer by one accepted event and queue its result
      function void predict_event(logic [2:0] act, logic [31:0] ts, logic ovr);
         rsp_item_type res;
         logic [31:0]  elapsed;
         res.timeout_fired = 1'b0;
         elapsed = ts - start_ts;
         case (act)
            ACT_OVERRIDE_END: begin
               if (mode == MODE_OVERRIDE || mode == MODE_IDLE) begin
                  mode       = MODE_CHECK;
                  start_ts   = ts;
                  stable_cnt = '0;
               end
            end
            ACT_STABLE_REPORT: begin
               if (mode == MODE_CHECK) begin
                  if (stable_cnt != COUNT_MAX)
                     stable_cnt++;
                  if (stable_cnt >= regs.stable_needed)
                     mode = MODE_READY;
               end
            end
            ACT_FIRST_OUTPUT: begin
               if (mode == MODE_READY)
                  mode = MODE_RESUMED;
            end
            ACT_FORCE_TIMEOUT: mode = MODE_TIMEOUT;
            ACT_SET_OVERRIDE: begin
               if (ovr)
                  mode = MODE_OVERRIDE;
            end
            ACT_CHECK_TIMEOUT: begin
               if (mode == MODE_CHECK && elapsed > regs.check_limit) begin
                  mode = MODE_TIMEOUT;
                  res.timeout_fired = 1'b1;
               end else if (mode == MODE_READY && elapsed > regs.output_timeout) begin
                  mode = MODE_TIMEOUT;
                  res.timeout_fired = 1'b1;
               end
            end
            default: ;
         endcase
         res.mode = mode;
         awaited_results.push_back(res);
      endfunction

      // Compare one result transfer with the oldest prediction
      function void check_result(logic [RSP_DATA_W-1:0] data);
         rsp_item_type got;
         rsp_item_type want;
         got = rsp_item_type'(data[3:0]);
         if (awaited_results.size() == 0) begin
            $display("%0t: result with no event pending, mode %0d fired %0b",
                     $time, got.mode, got.timeout_fired);
            fail_count++;
            return;
         end
         want = awaited_results.pop_front();
         if (got.mode !== want.mode) begin
            $display("%0t: mode mismatch, expected %0d actual %0d",
                     $time, want.mode, got.mode);
            fail_count++;
         end
         if (got.timeout_fired !== want.timeout_fired) begin
            $display("%0t: timeout_fired mismatch, expected %0b actual %0b",
                     $time, want.timeout_fired, got.timeout_fired);
            fail_count++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals and instance
   // -------------------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   resume_scoreboard sb = new();

   int unsigned gap_pct   = 0;
   int unsigned stall_pct = 0;
   int unsigned sent_events = 0;
   int unsigned cycles = 0;

   resume_sequencer_with_timeouts_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Abort a hung run
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Result side: check every transfer, stall in random bursts
   // -------------------------------------------------------------------------
   initial begin : result_sink
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(1, 14) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Event side
   // -------------------------------------------------------------------------
   // Present one event, optionally after an idle burst, and hold it until
   // the transfer
   task automatic send_event(logic [2:0] act, logic [31:0] ts, logic ovr);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {7'b0, ovr, ts};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sb.predict_event(act, ts, ovr);
      sent_events++;
   endtask

   // Stop sending and wait for every outstanding result, plus the pipeline
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.awaited_results.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Write all three registers back to back while the block is idle
   task automatic program_regs(logic [31:0] needed, logic [31:0] check_lim,
                               logic [31:0] output_lim);
      logic [CSR_IDX_W-1:0]  idx [3];
      logic [CSR_DATA_W-1:0] val [3];
      idx[0] = CSR_STABLE_NEEDED;  val[0] = needed;
      idx[1] = CSR_CHECK_TIMEOUT;  val[1] = check_lim;
      idx[2] = CSR_OUTPUT_TIMEOUT; val[2] = output_lim;
      drain();
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         while (!csr_ready)
            @(posedge clock);
         sb.write_reg(idx[i], val[i]);
      end
      csr_valid <= 1'b0;
   endtask

   // Pick a timestamp around the limit of the current mode
   function automatic logic [31:0] pick_check_ts();
      logic [31:0] lim;
      lim = (sb.mode == MODE_READY) ? sb.regs.output_timeout : sb.regs.check_limit;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return sb.start_ts + $urandom_range(0, lim);
         4:          return sb.start_ts + lim;
         5, 6:       return sb.start_ts + lim + 32'd1;
         7:          return $urandom();
         8:          return sb.start_ts - $urandom_range(1, 100);
         default:    return sb.start_ts + lim - 32'd1;
      endcase
   endfunction

   // One well-formed resume with random content, sometimes cut short
   task automatic resume_sequence();
      int reports;
      if ((sb.mode != MODE_IDLE && sb.mode != MODE_OVERRIDE) || $urandom_range(0, 1))
         send_event(ACT_SET_OVERRIDE, $urandom(), 1'b1);
      send_event(ACT_OVERRIDE_END, $urandom(), 1'($urandom_range(0, 1)));
      reports = (sb.regs.stable_needed == 0) ? 1 : sb.regs.stable_needed;
      case ($urandom_range(0, 7))
         0: reports = reports - 1;
         1: reports = reports + $urandom_range(1, 3);
         default: ;
      endcase
      for (int i = 0; i < reports; i++) begin
         if ($urandom_range(0, 3) == 0)
            send_event(ACT_CHECK_TIMEOUT, pick_check_ts(), 1'($urandom_range(0, 1)));
         send_event(ACT_STABLE_REPORT, $urandom(), 1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 1))
         send_event(ACT_CHECK_TIMEOUT, pick_check_ts(), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 9) != 0)
         send_event(ACT_FIRST_OUTPUT, $urandom(), 1'($urandom_range(0, 1)));
      case ($urandom_range(0, 5))
         0: send_event(ACT_CHECK_TIMEOUT, pick_check_ts(), 1'($urandom_range(0, 1)));
         1: send_event(ACT_FORCE_TIMEOUT, $urandom(), 1'($urandom_range(0, 1)));
         2: send_event(ACT_SET_OVERRIDE, $urandom(), 1'b0);
         default: ;
      endcase
   endtask

   // Mostly resume sequences, the rest random events of any code
   task automatic run_phase(int unsigned target, int unsigned gap, int unsigned stall);
      int unsigned first;
      gap_pct   = gap;
      stall_pct = stall;
      first     = sent_events;
      while (sent_events - first < target) begin
         if ($urandom_range(0, 4) == 0)
            send_event(3'($urandom_range(0, 7)), $urandom(), 1'($urandom_range(0, 1)));
         else
            resume_sequence();
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset register values, wrong-mode events, unused codes, wrap
      gap_pct   = 15;
      stall_pct = 15;
      send_event(ACT_STABLE_REPORT, 32'h0, 1'b0);
      send_event(ACT_CHECK_TIMEOUT, 32'hFFFF_FFFF, 1'b1);
      send_event(ACT_RESERVED_6, 32'hFFFF_FFFF, 1'b1);
      send_event(ACT_RESERVED_7, 32'h0, 1'b0);
      send_event(ACT_OVERRIDE_END, 32'hFFFF_FF00, 1'b0);
      send_event(ACT_CHECK_TIMEOUT, 32'hFFFF_FF00 + 32'd1000, 1'b0);
      repeat (3) send_event(ACT_STABLE_REPORT, 32'h5555_5555, 1'b1);
      send_event(ACT_FIRST_OUTPUT, 32'hAAAA_AAAA, 1'b0);
      send_event(ACT_OVERRIDE_END, 32'h1234_5678, 1'b0);
      send_event(ACT_SET_OVERRIDE, 32'h0, 1'b0);
      send_event(ACT_SET_OVERRIDE, 32'h0, 1'b1);
      send_event(ACT_OVERRIDE_END, 32'h0, 1'b1);
      send_event(ACT_CHECK_TIMEOUT, 32'd1001, 1'b0);
      send_event(ACT_FORCE_TIMEOUT, 32'h0, 1'b0);
      send_event(ACT_SET_OVERRIDE, 32'h0, 1'b1);
      send_event(ACT_OVERRIDE_END, 32'd100, 1'b0);
      repeat (3) send_event(ACT_STABLE_REPORT, 32'h0, 1'b0);
      send_event(ACT_CHECK_TIMEOUT, 32'd1100, 1'b0);
      send_event(ACT_CHECK_TIMEOUT, 32'd1101, 1'b1);

      // Random phases over a spread of register settings
      program_regs(32'd4, 32'd3000, 32'd20);
      run_phase(170, 20, 20);
      program_regs(32'd1, 32'd0, 32'd0);
      run_phase(110, 40, 10);
      program_regs(32'hFFFF_FF00, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      run_phase(110, 10, 40);
      program_regs(($urandom() & 32'hFFFF_FF00) | 32'd255, $urandom(),
                   $urandom_range(0, 50));
      run_phase(100, 15, 15);
      program_regs($urandom_range(1, 8), $urandom_range(0, 2000), $urandom_range(0, 2000));
      run_phase(120, 25, 25);

      // Last stretch at full rate on both sides
      program_regs(32'd2, 32'd500, 32'hFFFF_FFFE);
      stall_pct = 0;
      run_phase(100, 0, 0);

      drain();
      if (sb.fail_count == 0 && sb.awaited_results.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
